// ===== design/hwsp_pkg.sv =====
package hwsp_pkg;

  localparam int unsigned CHAR_W  = 8;
  localparam int unsigned WORD_W  = 64;
  localparam int unsigned COUNT_W = 5;
  localparam int unsigned DIGIT_W = 4;

  // character codes
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'd9;
  localparam logic [CHAR_W-1:0] CH_LF    = 8'd10;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'd13;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_UNDER = 8'h5F;
  localparam logic [CHAR_W-1:0] CH_0     = 8'h30;
  localparam logic [CHAR_W-1:0] CH_9     = 8'h39;
  localparam logic [CHAR_W-1:0] CH_LA    = 8'h61;
  localparam logic [CHAR_W-1:0] CH_LF_HEX = 8'h66;
  localparam logic [CHAR_W-1:0] CH_UA    = 8'h41;
  localparam logic [CHAR_W-1:0] CH_UF    = 8'h46;
  localparam logic [CHAR_W-1:0] CH_LX    = 8'h78;
  localparam logic [CHAR_W-1:0] CH_UX    = 8'h58;
  localparam logic [CHAR_W-1:0] CH_LZ    = 8'h7A;
  localparam logic [CHAR_W-1:0] CH_UZ    = 8'h5A;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_LONG = 2'd1,
    ST_BAD  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    CLS_DIGIT,
    CLS_SKIP,
    CLS_TERM,
    CLS_BAD
  } char_cls_t;

  typedef struct packed {
    char_cls_t            cls;
    logic [DIGIT_W-1:0]   digit;
  } char_info_t;

  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              last;
  } in_item_t;

  typedef struct packed {
    logic [WORD_W-1:0]  word;
    logic [COUNT_W-1:0] digit_count;
    status_t            status;
  } out_item_t;

endpackage

// ===== design/hwsp_if.sv =====
interface hwsp_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== design/hex_word_stream_parser.sv =====
// hex_word_stream_parser: hex text characters in, parsed words out
// an accepted character passes the input register, and the word it completes is held in the result register
// throughput: 1 character per cycle while the output takes words, set by the input and result registers
// the result register stalls only while a word waits on the output
// reset (rst, synchronous): word state, line skip and both valid flags cleared
module hex_word_stream_parser #(
  parameter int unsigned MAX_DIGITS = 16
) (
  input logic   clk,
  input logic   rst,
  hwsp_if.sink   in_chan,
  hwsp_if.source out_chan
);

  logic                        in_valid;
  hwsp_pkg::in_item_t          in_item;
  logic                        advance;
  hwsp_pkg::char_info_t        info;
  logic                        res_valid;
  hwsp_pkg::out_item_t         res;
  logic                        out_valid;
  hwsp_pkg::out_item_t         out_item;

  // the held character moves on once the result register is free
  assign advance       = in_valid && (!out_valid || out_chan.ready);
  assign in_chan.ready = !in_valid || advance;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_chan.ready) begin
      in_valid <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_chan.ready && in_chan.valid) begin
      in_item <= in_chan.data;
    end
  end

  hwsp_classify u_classify (
    .ch   (in_item.ch),
    .info (info)
  );

  hwsp_core #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .step      (advance),
    .ch        (in_item.ch),
    .last      (in_item.last),
    .info      (info),
    .res_valid (res_valid),
    .res       (res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= res_valid;
    end else if (out_chan.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res_valid) begin
      out_item <= res;
    end
  end

  assign out_chan.valid = out_valid;
  assign out_chan.data  = out_item;

`ifndef SYNTH
  // an empty input register always takes a request
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !in_valid |-> in_chan.ready)
    else $error("input register empty but not ready");

  // an invalid character reports no digits and a zero word
  a_bad_is_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_item.status == hwsp_pkg::ST_BAD) |->
      (out_item.word == '0 && out_item.digit_count == '0))
    else $error("error result carries data");

  // a finished word has between one and MAX_DIGITS digits
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_item.status != hwsp_pkg::ST_BAD) |->
      (out_item.digit_count != '0 &&
       out_item.digit_count <= hwsp_pkg::COUNT_W'(MAX_DIGITS)))
    else $error("digit count out of range");

  // an overlong word reports a saturated count
  a_long_saturates: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_item.status == hwsp_pkg::ST_LONG) |->
      out_item.digit_count == hwsp_pkg::COUNT_W'(MAX_DIGITS))
    else $error("overflow without saturated count");
`endif

endmodule

// ===== design/hwsp_classify.sv =====
module hwsp_classify (
  input  logic [hwsp_pkg::CHAR_W-1:0] ch,
  output hwsp_pkg::char_info_t        info
);

  // sort the byte into digit, skip, terminator or invalid
  always_comb begin
    info.cls   = hwsp_pkg::CLS_BAD;
    info.digit = '0;
    priority if (ch >= hwsp_pkg::CH_0 && ch <= hwsp_pkg::CH_9) begin
      info.cls   = hwsp_pkg::CLS_DIGIT;
      info.digit = hwsp_pkg::DIGIT_W'(ch - hwsp_pkg::CH_0);
    end else if (ch >= hwsp_pkg::CH_LA && ch <= hwsp_pkg::CH_LF_HEX) begin
      info.cls   = hwsp_pkg::CLS_DIGIT;
      info.digit = hwsp_pkg::DIGIT_W'(ch - hwsp_pkg::CH_LA + 8'd10);
    end else if (ch >= hwsp_pkg::CH_UA && ch <= hwsp_pkg::CH_UF) begin
      info.cls   = hwsp_pkg::CLS_DIGIT;
      info.digit = hwsp_pkg::DIGIT_W'(ch - hwsp_pkg::CH_UA + 8'd10);
    end else if (ch == hwsp_pkg::CH_LX || ch == hwsp_pkg::CH_UX ||
                 ch == hwsp_pkg::CH_LZ || ch == hwsp_pkg::CH_UZ) begin
      info.cls   = hwsp_pkg::CLS_DIGIT;
    end else if (ch == hwsp_pkg::CH_UNDER) begin
      info.cls   = hwsp_pkg::CLS_SKIP;
    end else if (ch == hwsp_pkg::CH_SPACE || ch == hwsp_pkg::CH_TAB ||
                 ch == hwsp_pkg::CH_CR || ch == hwsp_pkg::CH_LF) begin
      info.cls   = hwsp_pkg::CLS_TERM;
    end else begin
      info.cls   = hwsp_pkg::CLS_BAD;
    end
  end

endmodule

// ===== design/hwsp_core.sv =====
module hwsp_core #(
  parameter int unsigned MAX_DIGITS = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        step,
  input  logic [hwsp_pkg::CHAR_W-1:0] ch,
  input  logic                        last,
  input  hwsp_pkg::char_info_t        info,
  output logic                        res_valid,
  output hwsp_pkg::out_item_t         res
);

  localparam logic [hwsp_pkg::WORD_W-1:0] WORD_MASK =
    {hwsp_pkg::WORD_W{1'b1}} >> (hwsp_pkg::WORD_W - hwsp_pkg::DIGIT_W * MAX_DIGITS);
  localparam logic [hwsp_pkg::COUNT_W-1:0] MAX_CNT = hwsp_pkg::COUNT_W'(MAX_DIGITS);

  logic [hwsp_pkg::WORD_W-1:0]  accum, accum_next;
  logic [hwsp_pkg::COUNT_W-1:0] count, count_next;
  logic                         too_long, too_long_next;
  logic                         skipping_line, skipping_line_next;

  // next word state and result for one character
  always_comb begin
    accum_next         = accum;
    count_next         = count;
    too_long_next      = too_long;
    skipping_line_next = skipping_line;
    res_valid          = 1'b0;
    res.word           = accum;
    res.digit_count    = count;
    res.status         = too_long ? hwsp_pkg::ST_LONG : hwsp_pkg::ST_OK;

    if (skipping_line) begin
      if (ch == hwsp_pkg::CH_LF) begin
        skipping_line_next = 1'b0;
      end
    end else begin
      unique case (info.cls)
        hwsp_pkg::CLS_DIGIT: begin
          accum_next = {accum[hwsp_pkg::WORD_W-hwsp_pkg::DIGIT_W-1:0], info.digit} & WORD_MASK;
          if (count >= MAX_CNT) begin
            count_next    = MAX_CNT;
            too_long_next = 1'b1;
          end else begin
            count_next = count + 1'b1;
          end
        end
        hwsp_pkg::CLS_SKIP: begin
        end
        hwsp_pkg::CLS_TERM: begin
          if (count != '0) begin
            res_valid     = 1'b1;
            accum_next    = '0;
            count_next    = '0;
            too_long_next = 1'b0;
          end
        end
        default: begin
          res_valid          = 1'b1;
          res.word           = '0;
          res.digit_count    = '0;
          res.status         = hwsp_pkg::ST_BAD;
          accum_next         = '0;
          count_next         = '0;
          too_long_next      = 1'b0;
          skipping_line_next = 1'b1;
        end
      endcase
    end

    // end of stream flushes a pending word and starts clean
    if (last) begin
      if (!res_valid && count_next != '0) begin
        res_valid       = 1'b1;
        res.word        = accum_next;
        res.digit_count = count_next;
        res.status      = too_long_next ? hwsp_pkg::ST_LONG : hwsp_pkg::ST_OK;
      end
      accum_next         = '0;
      count_next         = '0;
      too_long_next      = 1'b0;
      skipping_line_next = 1'b0;
    end
  end

  // word state
  always_ff @(posedge clk) begin
    if (rst) begin
      accum         <= '0;
      count         <= '0;
      too_long      <= 1'b0;
      skipping_line <= 1'b0;
    end else if (step) begin
      accum         <= accum_next;
      count         <= count_next;
      too_long      <= too_long_next;
      skipping_line <= skipping_line_next;
    end
  end

endmodule
